/* hdl/lidet_pkg.sv */
// ----------------------------------------------------------------------------
// lidet_pkg
// Shared types, constants and register map of the lidar echo threshold
// detector.
// ----------------------------------------------------------------------------
package lidet_pkg;

   // Defaults of the top-level parameters.
   localparam int FRAME_LEN_DEF   = 1024;
   localparam int MAX_DET_DEF     = 8;
   localparam int SAMPLE_BITS_DEF = 16;

   // Fixed field and register widths.
   localparam int DIST_BITS = 27;
   localparam int MC_BITS   = 16;
   localparam int FRAC_BITS = 9;
   localparam int STEP_BITS = 16;
   localparam int OFS_BITS  = 20;

   // Register port.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_MIN_CONTRAST    = 2'd0;
   localparam logic [1:0] REG_THRESH_FRACTION = 2'd1;
   localparam logic [1:0] REG_DISTANCE_STEP   = 2'd2;
   localparam logic [1:0] REG_DISTANCE_OFFSET = 2'd3;

   // Register reset values.
   localparam logic [MC_BITS-1:0]   MIN_CONTRAST_RST    = 16'd200;
   localparam logic [FRAC_BITS-1:0] THRESH_FRACTION_RST = 9'd128;
   localparam logic [STEP_BITS-1:0] DISTANCE_STEP_RST   = 16'd1;
   localparam logic [OFS_BITS-1:0]  DISTANCE_OFFSET_RST = 20'd0;

   // Sequencer states of the scan engine.
   typedef enum logic [3:0] {
      ST_LOAD,
      ST_MINMUL,
      ST_DEPTH,
      ST_FRAC,
      ST_LIMIT,
      ST_READ,
      ST_MUL,
      ST_CMP,
      ST_PAD
   } lidet_state_type;

   // Control of the frame statistics unit.
   typedef struct packed {
      logic push;
      logic clear;
   } stats_ctl_type;

endpackage

/* hdl/lidet_frame_mem.sv */
// ----------------------------------------------------------------------------
// lidet_frame_mem
// Single-port-write, single-port-read frame buffer with a registered read.
// ----------------------------------------------------------------------------
module lidet_frame_mem #(
   parameter int DATA_W = 16,
   parameter int DEPTH  = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/lidet_frame_stats.sv */
// ----------------------------------------------------------------------------
// lidet_frame_stats
// Running sum, running minimum and write index of the frame being loaded.
// ----------------------------------------------------------------------------
module lidet_frame_stats
   import lidet_pkg::*;
#(
   parameter int FRAME_LEN   = FRAME_LEN_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  stats_ctl_type                                    ctl,
   input  logic signed [SAMPLE_BITS-1:0]                    sample,
   output logic signed [SAMPLE_BITS+$clog2(FRAME_LEN)-1:0]  sum,
   output logic signed [SAMPLE_BITS-1:0]                    min,
   output logic [$clog2(FRAME_LEN)-1:0]                     index,
   output logic                                             last
);

   localparam int IDX_W = $clog2(FRAME_LEN);
   localparam int SUM_W = SAMPLE_BITS + IDX_W;
   localparam logic signed [SAMPLE_BITS-1:0] MIN_RST = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

   logic signed [SUM_W-1:0]       sum_ff, sum_in;
   logic signed [SAMPLE_BITS-1:0] min_ff, min_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic                          last_idx;

   assign last_idx = (idx_ff == IDX_W'(FRAME_LEN - 1));

   always_comb begin
      sum_in = sum_ff;
      min_in = min_ff;
      idx_in = idx_ff;
      if (ctl.clear) begin
         sum_in = '0;
         min_in = MIN_RST;
         idx_in = '0;
      end else if (ctl.push) begin
         sum_in = sum_ff + SUM_W'(sample);
         min_in = (sample < min_ff) ? sample : min_ff;
         idx_in = last_idx ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         min_ff <= MIN_RST;
         idx_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         min_ff <= min_in;
         idx_ff <= idx_in;
      end
   end

   assign sum   = sum_ff;
   assign min   = min_ff;
   assign index = idx_ff;
   assign last  = last_idx;

endmodule

/* hdl/lidet_scan_engine.sv */
// ----------------------------------------------------------------------------
// lidet_scan_engine
// End-of-frame arithmetic, frame scan sequencer and result register.
// ----------------------------------------------------------------------------
module lidet_scan_engine
   import lidet_pkg::*;
#(
   parameter int FRAME_LEN   = FRAME_LEN_DEF,
   parameter int MAX_DET     = MAX_DET_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic [MC_BITS-1:0]                               cfg_min_contrast,
   input  logic [FRAC_BITS-1:0]                             cfg_fraction,
   input  logic [STEP_BITS-1:0]                             cfg_step,
   input  logic [OFS_BITS-1:0]                              cfg_offset,
   input  logic signed [SAMPLE_BITS+$clog2(FRAME_LEN)-1:0]  stats_sum,
   input  logic signed [SAMPLE_BITS-1:0]                    stats_min,
   input  logic                                             frame_full,
   output logic                                             load_ready,
   output logic                                             frame_clear,
   output logic [$clog2(FRAME_LEN)-1:0]                     mem_rd_addr,
   input  logic signed [SAMPLE_BITS-1:0]                    mem_rd_data,
   output logic                                             rsp_valid,
   input  logic                                             rsp_ready,
   output logic signed [DIST_BITS-1:0]                      rsp_distance,
   output logic signed [SAMPLE_BITS-1:0]                    rsp_intensity,
   output logic                                             rsp_found,
   output logic                                             rsp_last_of_run
);

   localparam int IDX_W  = $clog2(FRAME_LEN);
   localparam int SUM_W  = SAMPLE_BITS + IDX_W;
   localparam int DEP_W  = SUM_W;
   localparam int MC_W   = MC_BITS + IDX_W;
   localparam int FD_W   = SUM_W + FRAC_BITS;
   localparam int LIM_W  = SUM_W + 11;
   localparam int PROD_W = IDX_W + STEP_BITS;
   localparam int DET_W  = $clog2(MAX_DET + 1);
   localparam logic signed [SUM_W-1:0] N_EXT = SUM_W'(FRAME_LEN);

   lidet_state_type state_ff, state_in;
   logic [IDX_W-1:0]  scan_idx_ff, scan_idx_in;
   logic [DET_W-1:0]  det_ff, det_in;

   logic signed [SUM_W-1:0]     minn_ff;
   logic [MC_W-1:0]             mcn_ff;
   logic [DEP_W-1:0]            depth_ff;
   logic                        pass_ff;
   logic [FD_W-1:0]             fd_ff;
   logic signed [LIM_W-1:0]     lim_ff;
   logic signed [SUM_W-1:0]     prod_ff;
   logic [DIST_BITS-1:0]        dist_ff;
   logic signed [SUM_W:0]       diff;
   logic [PROD_W-1:0]           idx_prod;

   logic rsp_valid_ff;
   logic signed [DIST_BITS-1:0]   rsp_distance_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_intensity_ff;
   logic rsp_found_ff;
   logic rsp_last_ff;

   logic out_free;
   logic out_load;
   logic out_found;
   logic run_last;
   logic scan_last;
   logic hit;
   logic clear;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign run_last  = (det_ff == DET_W'(MAX_DET - 1));
   assign scan_last = (scan_idx_ff == IDX_W'(FRAME_LEN - 1));
   assign hit       = ((LIM_W'(prod_ff) <<< 8) < lim_ff);

   // Arithmetic chain; the operands hold still from the last sample until the
   // run ends, so each stage settles in the state named after it.
   assign diff     = (SUM_W+1)'(stats_sum) - (SUM_W+1)'(minn_ff);
   assign idx_prod = PROD_W'(scan_idx_ff) * PROD_W'(cfg_step);

   always_ff @(posedge clock) begin
      minn_ff  <= SUM_W'(stats_min) * N_EXT;
      mcn_ff   <= MC_W'(cfg_min_contrast) * MC_W'(FRAME_LEN);
      depth_ff <= diff[SUM_W] ? DEP_W'(-diff) : DEP_W'(diff);
      pass_ff  <= (depth_ff > mcn_ff);
      fd_ff    <= FD_W'(cfg_fraction) * FD_W'(depth_ff);
      lim_ff   <= (LIM_W'(stats_sum) <<< 8) - $signed(LIM_W'(fd_ff));
      prod_ff  <= SUM_W'(mem_rd_data) * N_EXT;
      dist_ff  <= DIST_BITS'(idx_prod) - DIST_BITS'(cfg_offset);
   end

   always_comb begin
      state_in    = state_ff;
      scan_idx_in = scan_idx_ff;
      det_in      = det_ff;
      out_load    = 1'b0;
      out_found   = 1'b0;
      clear       = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            det_in      = '0;
            scan_idx_in = '0;
            if (frame_full) begin
               state_in = ST_MINMUL;
            end
         end
         ST_MINMUL: state_in = ST_DEPTH;
         ST_DEPTH:  state_in = ST_FRAC;
         ST_FRAC:   state_in = ST_LIMIT;
         ST_LIMIT:  state_in = pass_ff ? ST_READ : ST_PAD;
         ST_READ:   state_in = ST_MUL;
         ST_MUL:    state_in = ST_CMP;
         ST_CMP: begin
            if (hit) begin
               if (out_free) begin
                  out_load  = 1'b1;
                  out_found = 1'b1;
                  det_in    = det_ff + 1'b1;
                  if (run_last) begin
                     clear    = 1'b1;
                     state_in = ST_LOAD;
                  end else if (scan_last) begin
                     state_in = ST_PAD;
                  end else begin
                     scan_idx_in = scan_idx_ff + 1'b1;
                     state_in    = ST_READ;
                  end
               end
            end else if (scan_last) begin
               state_in = ST_PAD;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_PAD: begin
            if (out_free) begin
               out_load = 1'b1;
               det_in   = det_ff + 1'b1;
               if (run_last) begin
                  clear    = 1'b1;
                  state_in = ST_LOAD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         scan_idx_ff <= '0;
         det_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         scan_idx_ff <= scan_idx_in;
         det_ff      <= det_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_distance_ff  <= out_found ? $signed(dist_ff) : '0;
         rsp_intensity_ff <= out_found ? mem_rd_data : '0;
         rsp_found_ff     <= out_found;
         rsp_last_ff      <= run_last;
      end
   end

   assign load_ready      = (state_ff == ST_LOAD);
   assign frame_clear     = clear;
   assign mem_rd_addr     = scan_idx_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_distance    = rsp_distance_ff;
   assign rsp_intensity   = rsp_intensity_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

/* hdl/lidar_echo_threshold_detector_core.sv */
// ----------------------------------------------------------------------------
// lidar_echo_threshold_detector_core
// Relative-amplitude echo detector over one buffered lidar waveform frame.
// ----------------------------------------------------------------------------
// Usage. Samples enter on the req_ channel, one beat per cycle while req_ready
// is high. Each beat is written into the frame buffer at the running write
// index, while the sum and the minimum of the frame are kept alongside.
// The beat that carries the last of FRAME_LEN samples closes the frame and
// req_ready falls. The arithmetic states MINMUL, DEPTH, FRAC and LIMIT then
// form the depth (frame sum against minimum times frame length), its check
// against min_contrast and the detection limit. If the frame passes, the
// buffer is scanned in order, each sample passing through buffer read,
// scaling multiply and compare, until MAX_DET detections are found or the
// frame ends; a flat frame skips the scan. Every frame yields exactly MAX_DET
// beats on the rsp_ channel: detections first, then padding beats at one per
// cycle while the receiver takes them, the last flagged last_of_run.
// A stalled receiver holds the scan at the next beat to emit; the output
// register lets the following frame start loading while the final beat still
// waits. Reset clears the statistics and the registers to their defaults;
// the buffer needs no clearing since every entry is rewritten before a scan.
// Registers must be written on the csr_ port only while the block is idle;
// the block itself does not enforce it.
// ----------------------------------------------------------------------------
module lidar_echo_threshold_detector_core
   import lidet_pkg::*;
#(
   parameter int FRAME_LEN   = FRAME_LEN_DEF,
   parameter int MAX_DET     = MAX_DET_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // Sample channel.
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   // Detection channel.
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [DIST_BITS-1:0]   rsp_distance,
   output logic signed [SAMPLE_BITS-1:0] rsp_intensity,
   output logic                          rsp_found,
   output logic                          rsp_last_of_run,
   // Register port.
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [CSR_DATA_W-1:0]         csr_pwdata,
   output logic [CSR_DATA_W-1:0]         csr_prdata,
   output logic                          csr_pready
);

   localparam int IDX_W = $clog2(FRAME_LEN);
   localparam int SUM_W = SAMPLE_BITS + IDX_W;

   // Configuration registers.
   logic [MC_BITS-1:0]   min_contrast_ff;
   logic [FRAC_BITS-1:0] fraction_ff;
   logic [STEP_BITS-1:0] step_ff;
   logic [OFS_BITS-1:0]  offset_ff;
   logic                 csr_write;
   logic [1:0]           csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         min_contrast_ff <= MIN_CONTRAST_RST;
         fraction_ff     <= THRESH_FRACTION_RST;
         step_ff         <= DISTANCE_STEP_RST;
         offset_ff       <= DISTANCE_OFFSET_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MIN_CONTRAST:    min_contrast_ff <= csr_pwdata[MC_BITS-1:0];
            REG_THRESH_FRACTION: fraction_ff     <= csr_pwdata[FRAC_BITS-1:0];
            REG_DISTANCE_STEP:   step_ff         <= csr_pwdata[STEP_BITS-1:0];
            REG_DISTANCE_OFFSET: offset_ff       <= csr_pwdata[OFS_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_MIN_CONTRAST:    csr_prdata = CSR_DATA_W'(min_contrast_ff);
         REG_THRESH_FRACTION: csr_prdata = CSR_DATA_W'(fraction_ff);
         REG_DISTANCE_STEP:   csr_prdata = CSR_DATA_W'(step_ff);
         REG_DISTANCE_OFFSET: csr_prdata = CSR_DATA_W'(offset_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // Sample intake.
   logic                          req_accept;
   logic                          frame_full;
   logic                          load_ready;
   logic                          frame_clear;
   stats_ctl_type                 stats_ctl;
   logic signed [SUM_W-1:0]       stats_sum;
   logic signed [SAMPLE_BITS-1:0] stats_min;
   logic [IDX_W-1:0]              stats_index;
   logic                          stats_last;
   logic [IDX_W-1:0]              mem_rd_addr;
   logic [SAMPLE_BITS-1:0]        mem_rd_data;

   assign req_ready  = load_ready;
   assign req_accept = req_valid && req_ready;
   assign frame_full = req_accept && stats_last;
   assign stats_ctl  = '{push: req_accept, clear: frame_clear};

   lidet_frame_stats #(
      .FRAME_LEN   (FRAME_LEN),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_stats (
      .clock  (clock),
      .reset  (reset),
      .ctl    (stats_ctl),
      .sample (req_sample),
      .sum    (stats_sum),
      .min    (stats_min),
      .index  (stats_index),
      .last   (stats_last)
   );

   // The buffer is written only while loading and read only while scanning,
   // so its two ports never touch the same entry in the same cycle.
   lidet_frame_mem #(
      .DATA_W (SAMPLE_BITS),
      .DEPTH  (FRAME_LEN)
   ) u_mem (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (stats_index),
      .wr_data (req_sample),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   lidet_scan_engine #(
      .FRAME_LEN   (FRAME_LEN),
      .MAX_DET     (MAX_DET),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .cfg_min_contrast (min_contrast_ff),
      .cfg_fraction     (fraction_ff),
      .cfg_step         (step_ff),
      .cfg_offset       (offset_ff),
      .stats_sum        (stats_sum),
      .stats_min        (stats_min),
      .frame_full       (frame_full),
      .load_ready       (load_ready),
      .frame_clear      (frame_clear),
      .mem_rd_addr      (mem_rd_addr),
      .mem_rd_data      (mem_rd_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_distance     (rsp_distance),
      .rsp_intensity    (rsp_intensity),
      .rsp_found        (rsp_found),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   // Once a frame is complete no further sample may enter until its run ends.
   a_frame_closes: assert property (@(posedge clock) disable iff (reset)
      frame_full |=> !req_ready)
      else $error("sample intake stayed open after the frame was complete");

   // Padding beats carry neither a distance nor an intensity.
   a_padding_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_distance == '0 && rsp_intensity == '0)
      else $error("padding beat with non-zero payload");

   // Ending a run leaves the statistics ready for a fresh frame.
   a_stats_cleared: assert property (@(posedge clock) disable iff (reset)
      frame_clear |=> stats_index == '0 && stats_sum == '0)
      else $error("frame statistics not cleared at the end of a run");

endmodule
